/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

/* rtl/core/jhdp_pkg.sv */
package jhdp_pkg;

    // One input item: a file byte and its end-of-file mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_item_t;

    // One result item: status and the even-rounded frame size.
    typedef struct packed {
        logic [2:0]  status;
        logic [16:0] width;
        logic [16:0] height;
    } out_item_t;

    // Result handed from the parser to the result register.
    typedef struct packed {
        logic      emit;
        out_item_t item;
    } step_result_t;

    // Status codes.
    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_PREFIX    = 3'd1;
    localparam logic [2:0] ST_SHORT_LEN = 3'd2;
    localparam logic [2:0] ST_NO_MARKER = 3'd3;
    localparam logic [2:0] ST_LIMIT     = 3'd4;
    localparam logic [2:0] ST_TRUNCATED = 3'd5;

    // Marker bytes.
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF1   = 8'hC1;
    localparam logic [7:0] MK_SOF2   = 8'hC2;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_SOS    = 8'hDA;

    // Reset value of the marker limit register.
    localparam logic [7:0] MAX_MARKERS_RESET = 8'd15;

endpackage

/* rtl/core/jpeg_header_dimension_parser_core.sv */
// JPEG frame size parser. One file byte enters per item on the in channel
// (valid/ready), with end_of_file set on the last byte of the file. The
// parser walks the marker segments and gives at most one result item per
// file on the out channel (valid/ready): status, and width and height
// rounded up to even when the status is found.
// A result passes through the input register and the result register on
// its way to out. Throughput: one byte per cycle while the receiver takes
// results; the single parser step between the input register and the
// result register sets that figure.
// When the result register is full and out_ready is low, the parser holds
// its byte and in_ready falls once the input register is full too.
// After the last byte of a file the parser returns to its start state and
// the next byte begins a new file.
// Reset clears both registers' valid flags and the parser state, and sets
// the marker limit to 15. The user writes the limit through cfg_write_en and
// cfg_write_data only while no file is in progress; the core does not check.
module jpeg_header_dimension_parser_core
    import jhdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item
);

    logic         hold_valid;
    in_item_t     hold_item;
    logic         free;
    logic         advance;
    step_result_t result;
    logic [7:0]   max_markers_reg;

    // Marker limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_markers_reg <= MAX_MARKERS_RESET;
        end
        else if (cfg_write_en)
        begin
            max_markers_reg <= cfg_write_data;
        end
    end

    // The parser takes its held byte whenever the result register has room.
    assign advance = hold_valid && free;

    jhdp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (advance),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    jhdp_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (hold_item),
        .max_markers (max_markers_reg),
        .result      (result)
    );

    jhdp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .result    (result),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

/* rtl/core/jhdp_in_stage.sv */
module jhdp_in_stage
    import jhdp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     take,
    output logic     hold_valid,
    output in_item_t hold_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register refills in the same cycle that the parser takes its item.
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

/* rtl/core/jhdp_step.sv */
`include "assert_macros.svh"

module jhdp_step
    import jhdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  in_item_t     item,
    input  logic [7:0]   max_markers,
    output step_result_t result
);

    typedef enum logic [3:0] {
        PH_SOI,
        PH_MARK_HI,
        PH_MARK_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_SOF_HDR,
        PH_H_HI,
        PH_H_LO,
        PH_W_HI,
        PH_W_LO,
        PH_SOS_LEN,
        PH_SOS_NC,
        PH_SOS_SKIP,
        PH_SCAN
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [16:0] skip_remaining_reg, skip_remaining_next;
    logic [7:0]  marker_count_reg, marker_count_next;
    logic [7:0]  high_byte_hold_reg, high_byte_hold_next;
    logic        saw_ff_reg, saw_ff_next;
    logic [15:0] height_hold_reg, height_hold_next;
    logic        finished_reg, finished_next;

    logic [7:0]  b;
    logic [7:0]  cnt_inc;
    logic [7:0]  cnt_inc2;
    logic [15:0] word;
    logic [16:0] skip_dec;
    logic        emit;
    out_item_t   res;

    assign b        = item.data_byte;
    assign cnt_inc  = marker_count_reg + 8'd1;
    assign cnt_inc2 = marker_count_reg + 8'd2;
    assign word     = {high_byte_hold_reg, b};
    assign skip_dec = skip_remaining_reg - 17'd1;

    // Parser step for one byte, then end-of-file handling.
    always_comb
    begin
        phase_next          = phase_reg;
        skip_remaining_next = skip_remaining_reg;
        marker_count_next   = marker_count_reg;
        high_byte_hold_next = high_byte_hold_reg;
        saw_ff_next         = saw_ff_reg;
        height_hold_next    = height_hold_reg;
        finished_next       = finished_reg;
        emit                = 1'b0;
        res                 = '0;

        if (!finished_reg)
        begin
            case (phase_reg)
                PH_SOI:
                begin
                    if (skip_remaining_reg != 17'd0)
                    begin
                        skip_remaining_next = 17'd0;
                        if (marker_count_reg >= max_markers)
                        begin
                            emit       = 1'b1;
                            res.status = ST_LIMIT;
                        end
                        else
                        begin
                            phase_next = PH_MARK_HI;
                        end
                    end
                    else
                    begin
                        skip_remaining_next = 17'd1;
                    end
                end
                PH_MARK_HI:
                begin
                    if (b != MK_PREFIX)
                    begin
                        emit       = 1'b1;
                        res.status = ST_PREFIX;
                    end
                    else
                    begin
                        phase_next = PH_MARK_LO;
                    end
                end
                PH_MARK_LO:
                begin
                    if (b == MK_EOI)
                    begin
                        marker_count_next = cnt_inc;
                        if (cnt_inc >= max_markers)
                        begin
                            emit       = 1'b1;
                            res.status = ST_LIMIT;
                        end
                        else
                        begin
                            phase_next = PH_MARK_HI;
                        end
                    end
                    else if (b inside {MK_SOF0, MK_SOF1, MK_SOF2})
                    begin
                        phase_next          = PH_SOF_HDR;
                        skip_remaining_next = 17'd3;
                    end
                    else if (b == MK_SOS)
                    begin
                        phase_next          = PH_SOS_LEN;
                        skip_remaining_next = 17'd2;
                    end
                    else
                    begin
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    high_byte_hold_next = b;
                    phase_next          = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    if (word < 16'd2)
                    begin
                        emit       = 1'b1;
                        res.status = ST_SHORT_LEN;
                    end
                    else if (word == 16'd2)
                    begin
                        marker_count_next = cnt_inc;
                        if (cnt_inc >= max_markers)
                        begin
                            emit       = 1'b1;
                            res.status = ST_LIMIT;
                        end
                        else
                        begin
                            phase_next = PH_MARK_HI;
                        end
                    end
                    else
                    begin
                        skip_remaining_next = {1'b0, word} - 17'd2;
                        phase_next          = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_remaining_next = skip_dec;
                    if (skip_dec == 17'd0)
                    begin
                        marker_count_next = cnt_inc;
                        if (cnt_inc >= max_markers)
                        begin
                            emit       = 1'b1;
                            res.status = ST_LIMIT;
                        end
                        else
                        begin
                            phase_next = PH_MARK_HI;
                        end
                    end
                end
                PH_SOF_HDR:
                begin
                    skip_remaining_next = skip_dec;
                    if (skip_dec == 17'd0)
                    begin
                        phase_next = PH_H_HI;
                    end
                end
                PH_H_HI:
                begin
                    high_byte_hold_next = b;
                    phase_next          = PH_H_LO;
                end
                PH_H_LO:
                begin
                    height_hold_next = word;
                    phase_next       = PH_W_HI;
                end
                PH_W_HI:
                begin
                    high_byte_hold_next = b;
                    phase_next          = PH_W_LO;
                end
                PH_W_LO:
                begin
                    emit       = 1'b1;
                    res.status = ST_FOUND;
                    res.width  = {1'b0, word} + {16'd0, word[0]};
                    res.height = {1'b0, height_hold_reg} + {16'd0, height_hold_reg[0]};
                end
                PH_SOS_LEN:
                begin
                    skip_remaining_next = skip_dec;
                    if (skip_dec == 17'd0)
                    begin
                        phase_next = PH_SOS_NC;
                    end
                end
                PH_SOS_NC:
                begin
                    // Two bytes per component plus the trailing header bytes.
                    skip_remaining_next = {8'd0, b, 1'b0} + 17'd3;
                    phase_next          = PH_SOS_SKIP;
                end
                PH_SOS_SKIP:
                begin
                    skip_remaining_next = skip_dec;
                    if (skip_dec == 17'd0)
                    begin
                        phase_next  = PH_SCAN;
                        saw_ff_next = 1'b0;
                    end
                end
                PH_SCAN:
                begin
                    // A stuffed zero after FF is data; only SOF0 or EOI ends the hunt.
                    if (saw_ff_reg && (b == MK_SOF0 || b == MK_EOI))
                    begin
                        saw_ff_next       = 1'b0;
                        marker_count_next = cnt_inc;
                        if (cnt_inc >= max_markers)
                        begin
                            emit       = 1'b1;
                            res.status = ST_LIMIT;
                        end
                        else if (b == MK_EOI)
                        begin
                            marker_count_next = cnt_inc2;
                            if (cnt_inc2 >= max_markers)
                            begin
                                emit       = 1'b1;
                                res.status = ST_LIMIT;
                            end
                            else
                            begin
                                phase_next = PH_MARK_HI;
                            end
                        end
                        else
                        begin
                            phase_next          = PH_SOF_HDR;
                            skip_remaining_next = 17'd3;
                        end
                    end
                    else
                    begin
                        saw_ff_next = (b == MK_PREFIX);
                    end
                end
                default:
                begin
                    phase_next = PH_SOI;
                end
            endcase
        end

        if (emit)
        begin
            finished_next = 1'b1;
        end

        // The last byte of a file closes it out and returns to reset state.
        if (item.end_of_file)
        begin
            if (!finished_reg && !emit)
            begin
                emit       = 1'b1;
                res        = '0;
                res.status = (phase_next == PH_SCAN) ? ST_NO_MARKER : ST_TRUNCATED;
            end
            phase_next          = PH_SOI;
            skip_remaining_next = 17'd0;
            marker_count_next   = 8'd0;
            high_byte_hold_next = 8'd0;
            saw_ff_next         = 1'b0;
            height_hold_next    = 16'd0;
            finished_next       = 1'b0;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_SOI;
            skip_remaining_reg <= 17'd0;
            marker_count_reg   <= 8'd0;
            high_byte_hold_reg <= 8'd0;
            saw_ff_reg         <= 1'b0;
            height_hold_reg    <= 16'd0;
            finished_reg       <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            skip_remaining_reg <= skip_remaining_next;
            marker_count_reg   <= marker_count_next;
            high_byte_hold_reg <= high_byte_hold_next;
            saw_ff_reg         <= saw_ff_next;
            height_hold_reg    <= height_hold_next;
            finished_reg       <= finished_next;
        end
    end

    assign result.emit = emit;
    assign result.item = res;

    `ASSERT_NEVER(a_no_emit_after_finish, clk, rst_n,
        advance && finished_reg && emit, "result given after the file was finished")
    `ASSERT_PROP(a_found_even, clk, rst_n,
        (advance && emit && res.status == ST_FOUND) |-> (!res.width[0] && !res.height[0]),
        "reported frame size is not even")
    `ASSERT_PROP(a_error_zero_size, clk, rst_n,
        (advance && emit && res.status != ST_FOUND) |-> (res.width == 17'd0 && res.height == 17'd0),
        "error result carries a frame size")
    `ASSERT_PROP(a_eof_clears, clk, rst_n,
        (advance && item.end_of_file) |=>
            (phase_reg == PH_SOI && marker_count_reg == 8'd0 && !finished_reg),
        "state not cleared after the last byte of a file")
    `ASSERT_PROP(a_result_finishes, clk, rst_n,
        (advance && emit && !item.end_of_file) |=> finished_reg,
        "parser not finished after giving a result")

endmodule

/* rtl/core/jhdp_out_stage.sv */
module jhdp_out_stage
    import jhdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  step_result_t result,
    output logic         free,
    output logic         out_valid,
    input  logic         out_ready,
    output out_item_t    out_item
);

    logic      valid_reg;
    logic      valid_next;
    logic      load;
    out_item_t item_reg;

    // The register can take a new result once the current one is gone.
    assign free = !valid_reg || out_ready;
    assign load = advance && result.emit;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result.item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* tb/jhdp_checker.sv */
module jhdp_checker
    import jhdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  in_item_t   in_item,
    input  logic       out_valid,
    input  logic       out_ready,
    input  out_item_t  out_item,
    output int         fail_count,
    output int         open_reports
);
    timeunit 1ns;
    timeprecision 1ps;

    // Where the marker walk stands within the file.
    typedef enum logic [3:0] {
        WALK_SOI,
        WALK_MARK_HI,
        WALK_MARK_LO,
        WALK_LEN_HI,
        WALK_LEN_LO,
        WALK_SKIP,
        WALK_SOF_HDR,
        WALK_H_HI,
        WALK_H_LO,
        WALK_W_HI,
        WALK_W_LO,
        WALK_SOS_LEN,
        WALK_SOS_NC,
        WALK_SOS_SKIP,
        WALK_SCAN
    } walk_phase_t;

    walk_phase_t walk;
    logic [16:0] skip_left;
    logic [7:0]  seg_count;
    logic [7:0]  hi_hold;
    logic [15:0] height_hold;
    logic        ff_seen;
    logic        done;
    logic        emitted;
    logic [7:0]  marker_limit;

    // Frame reports predicted but not yet seen on the out channel.
    out_item_t   frame_reports[$];
    out_item_t   want;

    task automatic clear_walk();
        walk        = WALK_SOI;
        skip_left   = '0;
        seg_count   = '0;
        hi_hold     = '0;
        height_hold = '0;
        ff_seen     = 1'b0;
        done        = 1'b0;
    endtask

    task automatic post_report(input logic [2:0] st, input logic [16:0] w,
                               input logic [16:0] h);
        out_item_t r;
        r.status = st;
        r.width  = w;
        r.height = h;
        frame_reports.push_back(r);
        emitted = 1'b1;
        done    = 1'b1;
    endtask

    // The limit is checked before every marker pair is read.
    task automatic open_marker();
        if (seg_count >= marker_limit)
            post_report(ST_LIMIT, '0, '0);
        else
            walk = WALK_MARK_HI;
    endtask

    task automatic close_segment();
        seg_count = seg_count + 8'd1;
        open_marker();
    endtask

    task automatic take_code(input logic [7:0] code);
        if (code == MK_EOI)
            close_segment();
        else if (code == MK_SOF0 || code == MK_SOF1 || code == MK_SOF2)
        begin
            walk      = WALK_SOF_HDR;
            skip_left = 17'd3;
        end
        else if (code == MK_SOS)
        begin
            walk      = WALK_SOS_LEN;
            skip_left = 17'd2;
        end
        else
            walk = WALK_LEN_HI;
    endtask

    // Advances the walk by one file byte and queues any report it causes.
    task automatic predict_frame_byte(input logic [7:0] b, input logic eof);
        logic        was_done;
        logic [16:0] word;
        was_done = done;
        emitted  = 1'b0;
        if (!was_done)
        begin
            case (walk)
                WALK_SOI:
                    if (skip_left != '0)
                    begin
                        skip_left = '0;
                        open_marker();
                    end
                    else
                        skip_left = 17'd1;
                WALK_MARK_HI:
                    if (b != MK_PREFIX)
                        post_report(ST_PREFIX, '0, '0);
                    else
                        walk = WALK_MARK_LO;
                WALK_MARK_LO:
                    take_code(b);
                WALK_LEN_HI:
                begin
                    hi_hold = b;
                    walk    = WALK_LEN_LO;
                end
                WALK_LEN_LO:
                begin
                    word = {1'b0, hi_hold, b};
                    if (word < 17'd2)
                        post_report(ST_SHORT_LEN, '0, '0);
                    else if (word == 17'd2)
                        close_segment();
                    else
                    begin
                        skip_left = word - 17'd2;
                        walk      = WALK_SKIP;
                    end
                end
                WALK_SKIP:
                begin
                    skip_left = skip_left - 17'd1;
                    if (skip_left == '0)
                        close_segment();
                end
                WALK_SOF_HDR:
                begin
                    skip_left = skip_left - 17'd1;
                    if (skip_left == '0)
                        walk = WALK_H_HI;
                end
                WALK_H_HI:
                begin
                    hi_hold = b;
                    walk    = WALK_H_LO;
                end
                WALK_H_LO:
                begin
                    height_hold = {hi_hold, b};
                    walk        = WALK_W_HI;
                end
                WALK_W_HI:
                begin
                    hi_hold = b;
                    walk    = WALK_W_LO;
                end
                WALK_W_LO:
                begin
                    word = {1'b0, hi_hold, b};
                    post_report(ST_FOUND, word + word[0],
                                {1'b0, height_hold} + height_hold[0]);
                end
                WALK_SOS_LEN:
                begin
                    skip_left = skip_left - 17'd1;
                    if (skip_left == '0)
                        walk = WALK_SOS_NC;
                end
                WALK_SOS_NC:
                begin
                    skip_left = {8'b0, b, 1'b0} + 17'd3;
                    walk      = WALK_SOS_SKIP;
                end
                WALK_SOS_SKIP:
                begin
                    skip_left = skip_left - 17'd1;
                    if (skip_left == '0)
                    begin
                        walk    = WALK_SCAN;
                        ff_seen = 1'b0;
                    end
                end
                WALK_SCAN:
                    // An SOF0 or end marker inside entropy data ends the scan.
                    if (ff_seen && (b == MK_SOF0 || b == MK_EOI))
                    begin
                        ff_seen   = 1'b0;
                        seg_count = seg_count + 8'd1;
                        if (seg_count >= marker_limit)
                            post_report(ST_LIMIT, '0, '0);
                        else
                            take_code(b);
                    end
                    else
                        ff_seen = (b == MK_PREFIX);
                default:
                    walk = WALK_SOI;
            endcase
        end

        // The last byte of a file reports why nothing was found, then restarts.
        if (eof)
        begin
            if (!was_done && !emitted)
                post_report((walk == WALK_SCAN) ? ST_NO_MARKER : ST_TRUNCATED, '0, '0);
            clear_walk();
        end
    endtask

    // Follow both channels and compare each result with the oldest report.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_walk();
            marker_limit = MAX_MARKERS_RESET;
            frame_reports.delete();
            fail_count   = 0;
            open_reports = 0;
        end
        else
        begin
            if (cfg_write_en)
                marker_limit = cfg_write_data;
            if (in_valid && in_ready)
                predict_frame_byte(in_item.data_byte, in_item.end_of_file);
            if (out_valid && out_ready)
            begin
                if (frame_reports.size() == 0)
                begin
                    $error("unexpected result item: status %0d width %0d height %0d",
                           out_item.status, out_item.width, out_item.height);
                    fail_count++;
                end
                else
                begin
                    want = frame_reports.pop_front();
                    if (out_item.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_item.status);
                        fail_count++;
                    end
                    if (out_item.width !== want.width)
                    begin
                        $error("width: expected %0d, got %0d", want.width, out_item.width);
                        fail_count++;
                    end
                    if (out_item.height !== want.height)
                    begin
                        $error("height: expected %0d, got %0d", want.height, out_item.height);
                        fail_count++;
                    end
                end
            end
            open_reports = frame_reports.size();
        end
    end

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jhdp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int QUIET_LIMIT  = 400;
    localparam int DRAIN_CYCLES = 8;

    // Application markers used as ordinary skipped segments.
    localparam logic [7:0] MK_APP0 = 8'hE0;
    localparam logic [7:0] MK_APP1 = 8'hE1;

    logic       clk;
    logic       rst_n          = 1'b0;
    logic       cfg_write_en   = 1'b0;
    logic [7:0] cfg_write_data = 8'd0;
    logic       in_valid       = 1'b0;
    logic       in_ready;
    in_item_t   in_item        = '0;
    logic       out_valid;
    logic       out_ready      = 1'b0;
    out_item_t  out_item;

    int         fail_count;
    int         open_reports;
    bit         idle_on        = 1'b1;
    int         stall_left     = 0;
    int         quiet          = 0;
    int         random_bytes   = 0;
    logic [7:0] file_q[$];

    jpeg_header_dimension_parser_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item)
    );

    jhdp_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .fail_count     (fail_count),
        .open_reports   (open_reports)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Result side: stalls come in bursts while idling is enabled.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Ends the run when neither channel has moved an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offers one byte, possibly after an idle burst, and waits for acceptance.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid          <= 1'b1;
        in_item.data_byte <= b;
        in_item.end_of_file <= eof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == file_q.size() - 1);
    endtask

    task automatic wait_drained();
        while (open_reports != 0)
            @(negedge clk);
    endtask

    // The limit is only changed between files with the parser idle.
    task automatic write_limit(input logic [7:0] v);
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    task automatic add_random(input int n);
        repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Length, precision, height and width of a frame header.
    task automatic add_frame_body();
        logic [15:0] dim;
        add_random(3);
        dim = pick_dim();
        file_q.push_back(dim[15:8]);
        file_q.push_back(dim[7:0]);
        dim = pick_dim();
        file_q.push_back(dim[15:8]);
        file_q.push_back(dim[7:0]);
    endtask

    task automatic add_frame();
        file_q.push_back(MK_PREFIX);
        case ($urandom_range(0, 2))
            0:       file_q.push_back(MK_SOF0);
            1:       file_q.push_back(MK_SOF1);
            default: file_q.push_back(MK_SOF2);
        endcase
        add_frame_body();
    endtask

    // A skipped segment with a short payload, now and then a broken length.
    task automatic add_other_segment();
        logic [7:0]  code;
        logic [15:0] seg_len;
        int          pick;
        do
            code = 8'($urandom_range(0, 255));
        while (code == MK_SOF0 || code == MK_SOF1 || code == MK_SOF2 ||
               code == MK_EOI || code == MK_SOS);
        pick = $urandom_range(0, 19);
        if (pick == 0)
            seg_len = 16'($urandom_range(0, 1));
        else if (pick < 5)
            seg_len = 16'd2;
        else
            seg_len = 16'($urandom_range(3, 12));
        file_q.push_back(MK_PREFIX);
        file_q.push_back(code);
        file_q.push_back(seg_len[15:8]);
        file_q.push_back(seg_len[7:0]);
        if (seg_len > 16'd2)
            add_random(seg_len - 2);
    endtask

    // Scan header and entropy data with escapes; ends_file is set when the
    // scan leaves no room for a later frame header.
    task automatic add_scan(output bit ends_file);
        int         nc;
        int         chunks;
        logic [7:0] b;
        file_q.push_back(MK_PREFIX);
        file_q.push_back(MK_SOS);
        add_random(2);
        nc = ($urandom_range(0, 29) == 0) ? 255 : $urandom_range(0, 3);
        file_q.push_back(8'(nc));
        add_random(2 * nc + 3);
        chunks = $urandom_range(0, 8);
        repeat (chunks)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    file_q.push_back(MK_PREFIX);
                    file_q.push_back(8'h00);
                end
                1:
                begin
                    file_q.push_back(MK_PREFIX);
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == MK_SOF0 || b == MK_EOI);
                    file_q.push_back(b);
                end
                default:
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == MK_PREFIX);
                    file_q.push_back(b);
                end
            endcase
        end
        case ($urandom_range(0, 3))
            0:
            begin
                file_q.push_back(MK_PREFIX);
                file_q.push_back(MK_SOF0);
                add_frame_body();
                ends_file = 1'b1;
            end
            2:
                ends_file = 1'b1;
            default:
            begin
                file_q.push_back(MK_PREFIX);
                file_q.push_back(MK_EOI);
                ends_file = 1'b0;
            end
        endcase
    endtask

    // Mostly well-formed files with random content; some are cut or damaged.
    task automatic build_file();
        int segs;
        int kind;
        int cut;
        bit ended;
        file_q.delete();
        add_random(2);
        ended = 1'b0;
        segs  = $urandom_range(0, 3);
        for (int s = 0; s < segs && !ended; s++)
        begin
            kind = $urandom_range(0, 3);
            if (kind < 2)
                add_other_segment();
            else if (kind == 2)
            begin
                file_q.push_back(MK_PREFIX);
                file_q.push_back(MK_EOI);
            end
            else
                add_scan(ended);
        end
        if (!ended)
            add_frame();
        add_random($urandom_range(0, 2));
        case ($urandom_range(0, 9))
            0:
            begin
                cut = $urandom_range(1, file_q.size());
                while (file_q.size() > cut)
                    void'(file_q.pop_back());
            end
            1:
                file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom_range(0, 255));
            default:
                ;
        endcase
    endtask

    task automatic run_random_files(input int n);
        repeat (n)
        begin
            build_file();
            send_file();
            random_bytes += file_q.size();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed files under the reset limit.
        // A file of one byte is cut short.
        file_q = {8'hD8};
        send_file();
        // Bad marker prefix.
        file_q = {8'hFF, 8'hD8, 8'h00};
        send_file();
        // Segment length below two.
        file_q = {8'hFF, 8'hD8, MK_PREFIX, MK_APP0, 8'h00, 8'h01};
        send_file();
        // Largest height and odd width, result on the final byte.
        file_q = {8'hFF, 8'hD8, MK_PREFIX, MK_SOF0, 8'h00, 8'h11, 8'h08,
                  8'hFF, 8'hFF, 8'h00, 8'h01};
        send_file();
        // Scan with an escaped prefix that runs out without a marker.
        file_q = {8'hFF, 8'hD8, MK_PREFIX, MK_SOS, 8'h00, 8'h08, 8'h00,
                  8'h11, 8'h22, 8'h33, MK_PREFIX, 8'h00};
        send_file();

        // Smallest limit.
        write_limit(8'd1);
        run_random_files(8);

        // Largest limit: a run of end markers reaches it, and a segment with
        // the largest length runs past the end of the file.
        write_limit(8'd255);
        file_q.delete();
        add_random(2);
        repeat (256)
        begin
            file_q.push_back(MK_PREFIX);
            file_q.push_back(MK_EOI);
        end
        add_random(1);
        send_file();
        file_q.delete();
        add_random(2);
        file_q.push_back(MK_PREFIX);
        file_q.push_back(MK_APP1);
        file_q.push_back(8'hFF);
        file_q.push_back(8'hFF);
        add_random(24);
        send_file();
        run_random_files(8);

        // Mostly small limits so that the limit check fires often.
        while (random_bytes < 900)
        begin
            if ($urandom_range(0, 3) == 0)
                write_limit(8'($urandom_range(1, 255)));
            else
                write_limit(8'($urandom_range(1, 6)));
            run_random_files(10);
        end

        // Last stretch at full rate on both sides.
        idle_on = 1'b0;
        write_limit(MAX_MARKERS_RESET);
        run_random_files(12);

        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* jpeg_header_dimension_parser_core.f */
+incdir+rtl/core
rtl/core/jhdp_pkg.sv
rtl/core/jhdp_in_stage.sv
rtl/core/jhdp_step.sv
rtl/core/jhdp_out_stage.sv
rtl/core/jpeg_header_dimension_parser_core.sv
tb/jhdp_checker.sv
tb/tb_top.sv
